// File: sv/srbd_pkg.sv
// Shared types, constants and helper functions of the SNMP response BER decoder.
`timescale 1ns / 1ps
package srbd_pkg;

    localparam int OID_ARCS_MAX_DEF = 32;
    localparam int STRING_BYTES_DEF = 64;
    localparam int CNT_W            = 7;
    localparam int LEN_W            = 24;
    localparam int Q_DEPTH          = 4;
    localparam int Q_AW             = $clog2(Q_DEPTH);
    localparam int MAX_RES          = 3;

    localparam logic [7:0] CFG_REQUEST_ID   = 8'd0;
    localparam logic [7:0] CFG_MAX_BINDINGS = 8'd1;

    localparam logic [1:0] KIND_ARC    = 2'd0;
    localparam logic [1:0] KIND_STRING = 2'd1;
    localparam logic [1:0] KIND_BEND   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_BAD   = 2'd1;
    localparam logic [1:0] STAT_OTHER = 2'd2;

    localparam logic [7:0] TAG_SEQ    = 8'h30;
    localparam logic [7:0] TAG_INT    = 8'h02;
    localparam logic [7:0] TAG_OCTETS = 8'h04;
    localparam logic [7:0] TAG_OID    = 8'h06;
    localparam logic [7:0] TAG_RESP   = 8'hA2;
    localparam logic [7:0] TAG_CNT32  = 8'h41;
    localparam logic [7:0] TAG_GAUGE  = 8'h42;
    localparam logic [7:0] TAG_TICKS  = 8'h43;
    localparam logic [7:0] TAG_CNT64  = 8'h46;

    localparam logic [2:0] NO_PARENT = 3'd4;

    typedef enum logic [10:0] {
        IT_VB    = 11'b000_0000_0001,
        IT_VER   = 11'b000_0000_0010,
        IT_COMM  = 11'b000_0000_0100,
        IT_PDU   = 11'b000_0000_1000,
        IT_RID   = 11'b000_0001_0000,
        IT_ESTAT = 11'b000_0010_0000,
        IT_EIDX  = 11'b000_0100_0000,
        IT_OID   = 11'b000_1000_0000,
        IT_VAL   = 11'b001_0000_0000,
        IT_LIST  = 11'b010_0000_0000,
        IT_MSG   = 11'b100_0000_0000
    } t_item;

    typedef enum logic [2:0] {
        ST_TAG  = 3'b001,
        ST_LEN  = 3'b010,
        ST_BODY = 3'b100
    } t_stage;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       packet_end;
    } t_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         binding_index;
        logic [5:0]         position;
        logic signed [63:0] value;
        logic [7:0]         value_tag;
        logic [1:0]         status;
        logic [7:0]         binding_count;
        logic               last;
    } t_out;

    typedef struct packed {
        logic [30:0] request_id;
        logic [7:0]  max_bindings;
    } t_cfg;

    function automatic logic [2:0] parent_of(input t_item it);
        unique case (it)
            IT_VB:                              parent_of = 3'd2;
            IT_VER, IT_COMM, IT_PDU:            parent_of = 3'd0;
            IT_RID, IT_ESTAT, IT_EIDX, IT_LIST: parent_of = 3'd1;
            IT_OID, IT_VAL:                     parent_of = 3'd3;
            default:                            parent_of = NO_PARENT;
        endcase
    endfunction

    function automatic logic [7:0] tag_of(input t_item it);
        unique case (it)
            IT_VB, IT_LIST, IT_MSG:             tag_of = TAG_SEQ;
            IT_VER, IT_RID, IT_ESTAT, IT_EIDX:  tag_of = TAG_INT;
            IT_COMM:                            tag_of = TAG_OCTETS;
            IT_PDU:                             tag_of = TAG_RESP;
            IT_OID:                             tag_of = TAG_OID;
            default:                            tag_of = 8'h00;
        endcase
    endfunction

    function automatic logic unsigned_tag(input logic [7:0] t);
        unsigned_tag = (t == TAG_CNT32) || (t == TAG_GAUGE) || (t == TAG_TICKS) ||
                       (t == TAG_CNT64);
    endfunction

    function automatic logic numeric_item(input t_item it, input logic [7:0] t);
        numeric_item = (it == IT_VER) || (it == IT_RID) || (it == IT_ESTAT) ||
                       ((it == IT_VAL) && ((t == TAG_INT) || unsigned_tag(t)));
    endfunction

    // Sign-extends a number of n bytes when asked; 8 and 9 bytes fill the word.
    function automatic logic [63:0] number_value(input logic [63:0] acc, input logic [3:0] n,
                                                 input logic [7:0] first, input logic sgn);
        logic [63:0] u;
        u = acc;
        if (sgn && first[7] && (n >= 4'd1) && (n < 4'd8)) begin
            u = u | ({64{1'b1}} << {n[2:0], 3'b000});
        end
        number_value = u;
    endfunction

    function automatic t_out mk_res(input logic [1:0] kind, input logic [7:0] idx,
                                    input logic [5:0] pos, input logic [63:0] val,
                                    input logic [7:0] tag, input logic [1:0] st,
                                    input logic [7:0] cnt);
        t_out r;
        r.kind          = kind;
        r.binding_index = idx;
        r.position      = pos;
        r.value         = val;
        r.value_tag     = tag;
        r.status        = st;
        r.binding_count = cnt;
        r.last          = 1'b0;
        mk_res = r;
    endfunction

endpackage

// File: sv/srbd_parser.sv
// BER parse state and per-byte next-state / result logic.
`timescale 1ns / 1ps
module srbd_parser #(
    parameter int OID_ARCS_MAX = srbd_pkg::OID_ARCS_MAX_DEF,
    parameter int STRING_BYTES = srbd_pkg::STRING_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  srbd_pkg::t_in  i_in,
    input  srbd_pkg::t_cfg i_cfg,
    output srbd_pkg::t_out o_res [srbd_pkg::MAX_RES],
    output logic [1:0]     o_res_cnt
);
    import srbd_pkg::*;

    localparam logic [CNT_W-1:0] ARC_LIM = CNT_W'(OID_ARCS_MAX);
    localparam logic [CNT_W-1:0] STR_LIM = CNT_W'(STRING_BYTES);

    t_item            r_item,  n_item;
    t_stage           r_stage, n_stage;
    logic [LEN_W-1:0] r_lvl [5];
    logic [LEN_W-1:0] n_lvl [5];
    logic [7:0]       r_tag,   n_tag;
    logic [LEN_W-1:0] r_lacc,  n_lacc;
    logic [1:0]       r_lbl,   n_lbl;
    logic [63:0]      r_nacc,  n_nacc;
    logic [3:0]       r_nlen,  n_nlen;
    logic [7:0]       r_first, n_first;
    logic [34:0]      r_sacc,  n_sacc;
    logic [2:0]       r_scnt,  n_scnt;
    logic [CNT_W-1:0] r_arc,   n_arc;
    logic [CNT_W-1:0] r_str,   n_str;
    logic [7:0]       r_bind,  n_bind;
    logic [1:0]       r_outc,  n_outc;
    logic             r_fin,   n_fin;

    always_comb begin
        logic [7:0]       b;
        logic [2:0]       p;
        logic             failed, hd, leaf, nb;
        logic [LEN_W-1:0] hd_len;
        logic [6:0]       nlong;
        logic [34:0]      v;
        logic [1:0]       a;
        logic [63:0]      nv;
        logic [1:0]       st;
        logic [1:0]       nres;
        t_out             res [MAX_RES];

        b       = i_in.packet_byte;
        p       = parent_of(r_item);
        failed  = 1'b0;
        hd      = 1'b0;
        leaf    = 1'b0;
        nb      = 1'b0;
        hd_len  = '0;
        nlong   = b[6:0];
        v       = '0;
        a       = 2'd0;
        nv      = '0;
        st      = STAT_OK;
        nres    = 2'd0;
        for (int k = 0; k < MAX_RES; k++) res[k] = '0;

        n_item  = r_item;
        n_stage = r_stage;
        for (int k = 0; k < 5; k++) n_lvl[k] = r_lvl[k];
        n_tag   = r_tag;
        n_lacc  = r_lacc;
        n_lbl   = r_lbl;
        n_nacc  = r_nacc;
        n_nlen  = r_nlen;
        n_first = r_first;
        n_sacc  = r_sacc;
        n_scnt  = r_scnt;
        n_arc   = r_arc;
        n_str   = r_str;
        n_bind  = r_bind;
        n_outc  = r_outc;
        n_fin   = r_fin;

        if (r_fin) begin
            if (n_lvl[0] != '0) n_lvl[0] = n_lvl[0] - 1'b1;
        end else begin
            for (int k = 0; k < 4; k++) begin
                if ((p != NO_PARENT) && (3'(k) <= p) && (n_lvl[k] != '0))
                    n_lvl[k] = n_lvl[k] - 1'b1;
            end
            if (r_stage == ST_BODY) begin
                if (r_item == IT_VB) begin
                    if (n_lvl[3] != '0) n_lvl[3] = n_lvl[3] - 1'b1;
                end else if (n_lvl[4] != '0) begin
                    n_lvl[4] = n_lvl[4] - 1'b1;
                end
            end

            unique case (r_stage)
                ST_TAG: begin
                    if ((b[4:0] == 5'h1f) || ((r_item != IT_VAL) && (b != tag_of(r_item)))) begin
                        failed = 1'b1;
                    end else begin
                        n_tag   = b;
                        n_stage = ST_LEN;
                    end
                end
                ST_LEN: begin
                    if (r_lbl == 2'd0) begin
                        if (b[7]) begin
                            if ((nlong < 7'd1) || (nlong > 7'd3) ||
                                ((p != NO_PARENT) && (LEN_W'(nlong) > n_lvl[p]))) begin
                                failed = 1'b1;
                            end else begin
                                n_lbl  = nlong[1:0];
                                n_lacc = '0;
                            end
                        end else begin
                            hd     = 1'b1;
                            hd_len = LEN_W'(b);
                        end
                    end else begin
                        n_lacc = {r_lacc[LEN_W-9:0], b};
                        n_lbl  = r_lbl - 2'd1;
                        if (n_lbl == 2'd0) begin
                            hd     = 1'b1;
                            hd_len = n_lacc;
                        end
                    end
                end
                ST_BODY: begin
                    if (r_item == IT_VB) begin
                        if (n_lvl[3] == '0) nb = 1'b1;
                    end else if (numeric_item(r_item, r_tag)) begin
                        if (({1'b0, n_lvl[4]} + 1'b1) == (LEN_W+1)'(r_nlen)) begin
                            n_first = b;
                            if ((r_nlen == 4'd9) && (b != 8'd0)) failed = 1'b1;
                        end
                        if (!failed) n_nacc = {r_nacc[55:0], b};
                    end else if (r_item == IT_OID) begin
                        n_scnt = r_scnt + 3'd1;
                        if (n_scnt > 3'd5) begin
                            failed = 1'b1;
                        end else begin
                            n_sacc = {r_sacc[27:0], b[6:0]};
                            if (!b[7]) begin
                                v      = n_sacc;
                                n_sacc = '0;
                                n_scnt = 3'd0;
                                if (v[34:32] != 3'd0) begin
                                    failed = 1'b1;
                                end else if (r_arc == '0) begin
                                    a = (v < 35'd40) ? 2'd0 : ((v < 35'd80) ? 2'd1 : 2'd2);
                                    res[0] = mk_res(KIND_ARC, r_bind, 6'd0, 64'(a), 8'd0,
                                                    STAT_OK, 8'd0);
                                    res[1] = mk_res(KIND_ARC, r_bind, 6'd1,
                                                    64'(v - 35'd40 * 35'(a)), 8'd0,
                                                    STAT_OK, 8'd0);
                                    nres   = 2'd2;
                                    n_arc  = CNT_W'(2);
                                end else if (r_arc >= ARC_LIM) begin
                                    failed = 1'b1;
                                end else begin
                                    res[0] = mk_res(KIND_ARC, r_bind, r_arc[5:0], 64'(v),
                                                    8'd0, STAT_OK, 8'd0);
                                    nres   = 2'd1;
                                    n_arc  = r_arc + 1'b1;
                                end
                            end
                        end
                    end else if ((r_item == IT_VAL) && (r_tag == TAG_OCTETS)) begin
                        if (r_str < STR_LIM) begin
                            res[0] = mk_res(KIND_STRING, r_bind, r_str[5:0], 64'(b), 8'd0,
                                            STAT_OK, 8'd0);
                            nres   = 2'd1;
                            n_str  = r_str + 1'b1;
                        end
                    end
                    if ((r_item != IT_VB) && !failed && (n_lvl[4] == '0)) leaf = 1'b1;
                end
                default: failed = 1'b1;
            endcase

            // header complete: open a level or start an element body
            if (hd && !failed) begin
                if ((p != NO_PARENT) && (hd_len > n_lvl[p])) begin
                    failed = 1'b1;
                end else begin
                    unique case (r_item)
                        IT_MSG: begin
                            n_lvl[0] = hd_len;
                            if (n_lvl[0] < 24'd2) failed = 1'b1;
                            else begin n_item = IT_VER; n_stage = ST_TAG; end
                        end
                        IT_PDU: begin
                            n_lvl[1] = hd_len;
                            if (n_lvl[1] < 24'd2) failed = 1'b1;
                            else begin n_item = IT_RID; n_stage = ST_TAG; end
                        end
                        IT_LIST: begin
                            n_lvl[2] = hd_len;
                            nb       = 1'b1;
                        end
                        IT_VB: begin
                            n_lvl[3] = hd_len;
                            n_arc    = '0;
                            n_sacc   = '0;
                            n_scnt   = 3'd0;
                            if (n_lvl[3] < 24'd2) failed = 1'b1;
                            else begin n_item = IT_OID; n_stage = ST_TAG; end
                        end
                        default: begin
                            if (numeric_item(r_item, r_tag)) begin
                                if ((hd_len < 24'd1) || (hd_len > 24'd9)) failed = 1'b1;
                                else begin
                                    n_nlen  = hd_len[3:0];
                                    n_nacc  = '0;
                                    n_first = 8'd0;
                                end
                            end
                            if (!failed && (r_item == IT_OID) && (hd_len == '0))
                                failed = 1'b1;
                            if (!failed) begin
                                n_str    = '0;
                                n_lvl[4] = hd_len;
                                n_stage  = ST_BODY;
                                if (hd_len == '0) leaf = 1'b1;
                            end
                        end
                    endcase
                end
            end

            // element body complete
            if (leaf && !failed) begin
                nv = number_value(n_nacc, n_nlen, n_first, 1'b1);
                unique case (r_item)
                    IT_VER: begin
                        if (nv != 64'd1) failed = 1'b1;
                        else if (n_lvl[0] < 24'd2) failed = 1'b1;
                        else begin n_item = IT_COMM; n_stage = ST_TAG; end
                    end
                    IT_COMM: begin
                        if (n_lvl[0] < 24'd2) failed = 1'b1;
                        else begin n_item = IT_PDU; n_stage = ST_TAG; end
                    end
                    IT_RID: begin
                        if (nv != 64'(i_cfg.request_id)) begin
                            n_outc = STAT_OTHER;
                            n_fin  = 1'b1;
                        end else if (n_lvl[1] < 24'd2) failed = 1'b1;
                        else begin n_item = IT_ESTAT; n_stage = ST_TAG; end
                    end
                    IT_ESTAT: begin
                        if (nv != 64'd0) failed = 1'b1;
                        else if (n_lvl[1] < 24'd2) failed = 1'b1;
                        else begin n_item = IT_EIDX; n_stage = ST_TAG; end
                    end
                    IT_EIDX: begin
                        if (n_lvl[1] < 24'd2) failed = 1'b1;
                        else begin n_item = IT_LIST; n_stage = ST_TAG; end
                    end
                    IT_OID: begin
                        if ((n_scnt != 3'd0) || (n_arc < CNT_W'(2))) failed = 1'b1;
                        else if (n_lvl[3] < 24'd2) failed = 1'b1;
                        else begin n_item = IT_VAL; n_stage = ST_TAG; end
                    end
                    IT_VAL: begin
                        if (r_tag == TAG_INT) nv = number_value(n_nacc, n_nlen, n_first, 1'b1);
                        else if (unsigned_tag(r_tag))
                            nv = number_value(n_nacc, n_nlen, n_first, 1'b0);
                        else nv = 64'd0;
                        res[nres] = mk_res(KIND_BEND, n_bind, 6'd0, nv, r_tag, STAT_OK, 8'd0);
                        nres      = nres + 2'd1;
                        if (n_bind != 8'd255) n_bind = n_bind + 8'd1;
                        n_item  = IT_VB;
                        n_stage = ST_BODY;
                        if (n_lvl[3] == '0) nb = 1'b1;
                    end
                    default: failed = 1'b1;
                endcase
            end

            // move on to the next binding, or stop at list end / binding limit
            if (nb && !failed) begin
                if ((n_lvl[2] == '0) || (n_bind >= i_cfg.max_bindings)) n_fin = 1'b1;
                else if (n_lvl[2] < 24'd2) failed = 1'b1;
                else begin n_item = IT_VB; n_stage = ST_TAG; end
            end

            if (failed) begin
                n_outc = STAT_BAD;
                n_fin  = 1'b1;
            end
        end

        if (i_in.packet_end) begin
            if (!n_fin || (n_outc == STAT_BAD) || (n_lvl[0] != '0)) st = STAT_BAD;
            else st = n_outc;
            res[nres] = mk_res(KIND_STATUS, 8'd0, 6'd0, 64'd0, 8'd0, st,
                               (st == STAT_OK) ? n_bind : 8'd0);
            nres = nres + 2'd1;
            n_item  = IT_MSG;
            n_stage = ST_TAG;
            for (int k = 0; k < 5; k++) n_lvl[k] = '0;
            n_tag   = 8'd0;
            n_lacc  = '0;
            n_lbl   = 2'd0;
            n_nacc  = '0;
            n_nlen  = 4'd0;
            n_first = 8'd0;
            n_sacc  = '0;
            n_scnt  = 3'd0;
            n_arc   = '0;
            n_str   = '0;
            n_bind  = 8'd0;
            n_outc  = STAT_OK;
            n_fin   = 1'b0;
        end

        if (nres != 2'd0) res[nres - 2'd1].last = 1'b1;
        for (int k = 0; k < MAX_RES; k++) o_res[k] = res[k];
        o_res_cnt = nres;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item  <= IT_MSG;
            r_stage <= ST_TAG;
            for (int k = 0; k < 5; k++) r_lvl[k] <= '0;
            r_tag   <= 8'd0;
            r_lacc  <= '0;
            r_lbl   <= 2'd0;
            r_nacc  <= '0;
            r_nlen  <= 4'd0;
            r_first <= 8'd0;
            r_sacc  <= '0;
            r_scnt  <= 3'd0;
            r_arc   <= '0;
            r_str   <= '0;
            r_bind  <= 8'd0;
            r_outc  <= STAT_OK;
            r_fin   <= 1'b0;
        end else if (i_take) begin
            r_item  <= n_item;
            r_stage <= n_stage;
            for (int k = 0; k < 5; k++) r_lvl[k] <= n_lvl[k];
            r_tag   <= n_tag;
            r_lacc  <= n_lacc;
            r_lbl   <= n_lbl;
            r_nacc  <= n_nacc;
            r_nlen  <= n_nlen;
            r_first <= n_first;
            r_sacc  <= n_sacc;
            r_scnt  <= n_scnt;
            r_arc   <= n_arc;
            r_str   <= n_str;
            r_bind  <= n_bind;
            r_outc  <= n_outc;
            r_fin   <= n_fin;
        end
    end

endmodule

// File: sv/srbd_queue.sv
// Result queue: takes up to three results per byte, hands out one per beat.
`timescale 1ns / 1ps
module srbd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  srbd_pkg::t_out i_res [srbd_pkg::MAX_RES],
    input  logic [1:0]     i_res_cnt,
    output logic           o_room,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output srbd_pkg::t_out o_out_data
);
    import srbd_pkg::*;

    t_out          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_cnt, n_cnt;
    logic            pop;
    logic [1:0]      add;

    assign pop         = (r_cnt != '0) && !i_out_stall;
    assign add         = i_push ? i_res_cnt : 2'd0;
    assign n_cnt       = r_cnt + (Q_AW+1)'(add) - (Q_AW+1)'(pop);
    assign o_room      = r_cnt <= (Q_AW+1)'(Q_DEPTH - MAX_RES);
    assign o_out_valid = r_cnt != '0;
    assign o_out_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (2'(k) < add) r_mem[r_wr + Q_AW'(k)] <= i_res[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + Q_AW'(add);
            r_rd  <= r_rd + Q_AW'(pop);
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: sv/snmp_response_ber_decoder_unit.sv
// Top level of the SNMPv2c response BER decoder.
`timescale 1ns / 1ps
// Decodes an SNMPv2c response datagram arriving one byte per input beat and
// emits OID arcs, string bytes, a binding-end per variable binding and a
// packet status on the byte flagged packet_end. Every byte is parsed in the
// cycle it is taken: the parse state registers feed one layer of next-state
// logic, so a byte can be accepted every cycle. Results (up to three per
// byte) go into a four-entry result queue that drains one result per beat;
// input is stalled while the queue holds more than one result. A byte that
// yields at most one result can follow the previous one with no gap. With the
// consumer ready, a byte that yields two results, or three (first OID
// arcs plus status, or a string byte with its binding end and status),
// stalls the input while the queue drains; a stalling consumer holds the input
// back as soon as two results wait. On any status other than ok the
// consumer must drop the bindings of that datagram. Configuration writes
// (request_id, max_bindings) are always ready and must be done while idle.
module snmp_response_ber_decoder_unit #(
    parameter int OID_ARCS_MAX = srbd_pkg::OID_ARCS_MAX_DEF,
    parameter int STRING_BYTES = srbd_pkg::STRING_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  srbd_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output srbd_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [7:0]     i_cfg_index,
    input  logic [30:0]    i_cfg_data
);
    import srbd_pkg::*;

    t_cfg       r_cfg;
    t_out       res [MAX_RES];
    logic [1:0] res_cnt;
    logic       room;
    logic       take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !room;
    assign take        = i_in_valid && room;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.request_id   <= 31'd1;
            r_cfg.max_bindings <= 8'd24;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REQUEST_ID:   r_cfg.request_id   <= i_cfg_data;
                CFG_MAX_BINDINGS: r_cfg.max_bindings <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    srbd_parser #(
        .OID_ARCS_MAX (OID_ARCS_MAX),
        .STRING_BYTES (STRING_BYTES)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_in      (i_in_data),
        .i_cfg     (r_cfg),
        .o_res     (res),
        .o_res_cnt (res_cnt)
    );

    srbd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (take),
        .i_res       (res),
        .i_res_cnt   (res_cnt),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: sv/srbd_checker.sv
// Port-level assertions for the decoder, bound to the top level.
`timescale 1ns / 1ps
module srbd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input srbd_pkg::t_out o_out_data
);
    import srbd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_STATUS) |->
        (o_out_data.binding_index == 8'd0) && (o_out_data.position == 6'd0) &&
        o_out_data.last)
        else $error("status beat with binding fields or not last");

    a_nonstatus_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind != KIND_STATUS) |->
        (o_out_data.status == STAT_OK) && (o_out_data.binding_count == 8'd0))
        else $error("status fields set on a binding beat");

    a_bad_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != STAT_OK) |-> (o_out_data.binding_count == 8'd0))
        else $error("binding count given with failing status");

    a_string_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_STRING) |-> (o_out_data.value[63:8] == '0))
        else $error("string beat wider than a byte");

endmodule

bind snmp_response_ber_decoder_unit srbd_checker u_srbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
